// ----- sv/ivt_pkg.sv -----
package ivt_pkg;

    localparam int NUM_CHANNELS = 3;

    // Item operation codes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_GATE  = 3'd3;
    localparam logic [2:0] OP_POLL  = 3'd4;

    // I/O map
    localparam logic [15:0] PORT_CH0 = 16'h0040;
    localparam logic [15:0] PORT_CMD = 16'h0043;

    // Access field of the control word
    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_LO    = 2'd1;
    localparam logic [1:0] ACC_HI    = 2'd2;
    localparam logic [1:0] ACC_LOHI  = 2'd3;

    // Select field value of the read-back command
    localparam logic [1:0] SEL_READBACK = 2'd3;

    localparam logic [2:0] MODE_RATE   = 3'd2;
    localparam logic [2:0] MODE_SQUARE = 3'd3;

    // Per-channel strobes for one item, already qualified by the transfer
    typedef struct packed {
        logic       tick;
        logic       rd;
        logic       wr;
        logic       cmd;
        logic [7:0] data;
    } chan_ctl_t;

    typedef struct packed {
        logic [7:0]  rd_data;
        logic        restart;
        logic [15:0] reload_next;
    } chan_sts_t;

    // Reload of zero counts as 65536
    function automatic logic [16:0] divisor_of(input logic [15:0] reload);
        divisor_of = (reload == 16'd0) ? 17'h10000 : {1'b0, reload};
    endfunction

endpackage

// ----- sv/interval_timer_three_channel.sv -----
// Three-channel interval timer modeled on the classic 8254, driven by tick items
// instead of a timer clock. Each input transfer is one operation: a tick, a read or
// write of ports 0x40-0x43, a channel 2 gate change, or a poll of the channel 0
// interrupt; each produces exactly one result transfer. Throughput is one item per
// clock unless out_stall holds the flow; an item passes the input register, then
// the result register, and all its state is updated as it moves between the two,
// so the next item always sees it. out_stall backs up into in_stall only when both
// registers are full. Reload of 0 means 65536; channel 0 flags an interrupt every
// max(divisor, MIN_IRQ_TICKS) ticks, missed firings merging into one.
module interval_timer_three_channel #(
    parameter int MIN_IRQ_TICKS = 1193
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [15:0] port,
    input  logic [7:0]  write_data,
    input  logic        gate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        irq0_fired,
    output logic        out2_high,
    output logic        gate_state
);

    localparam logic [16:0] MinTicks = 17'(MIN_IRQ_TICKS);
    localparam logic [16:0] ElapsedMax = 17'h10000;

    // Input register
    logic        in_vld_reg, in_vld_next;
    logic [2:0]  op_reg;
    logic [15:0] port_reg;
    logic [7:0]  data_reg;
    logic        gate_in_reg;

    // Result register
    logic        out_vld_reg, out_vld_next;
    logic [7:0]  read_data_reg, read_data_next;
    logic        fired_reg, fired_next;
    logic        out2_reg, out2_next;
    logic        gate_out_reg;

    // Global timer state
    logic [16:0] elapsed_reg, elapsed_next;
    logic        gate_lvl_reg, gate_lvl_next;
    logic        irq_en_reg, irq_en_next;
    logic [16:0] irq_cd_reg, irq_cd_next;
    logic        irq_pend_reg, irq_pend_next;

    logic advance, fire, accept;
    logic is_tick, is_read, is_write, is_gate, is_poll;
    logic chan_hit, cmd_hit;
    logic [1:0] chan_idx, cmd_sel;
    logic [16:0] div0_cur, div0_new, div2_new, irq_cd_dec;

    ivt_pkg::chan_ctl_t ctl [ivt_pkg::NUM_CHANNELS];
    ivt_pkg::chan_sts_t sts [ivt_pkg::NUM_CHANNELS];
    logic [15:0] reload0_reg;

    // Handshake: the input stage moves on whenever the result slot is free or draining
    assign advance  = !out_vld_reg || !out_stall;
    assign fire     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign in_vld_next  = accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? in_vld_reg : out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op;
            port_reg    <= port;
            data_reg    <= write_data;
            gate_in_reg <= gate;
        end
    end

    // Decode of the held item
    assign is_tick  = fire && (op_reg == ivt_pkg::OP_TICK);
    assign is_read  = fire && (op_reg == ivt_pkg::OP_READ);
    assign is_write = fire && (op_reg == ivt_pkg::OP_WRITE);
    assign is_gate  = fire && (op_reg == ivt_pkg::OP_GATE);
    assign is_poll  = fire && (op_reg == ivt_pkg::OP_POLL);

    // 0x40..0x42 are data ports
    assign chan_idx = port_reg[1:0];
    assign chan_hit = (port_reg[15:2] == ivt_pkg::PORT_CH0[15:2]) && (chan_idx != 2'd3);
    assign cmd_sel  = data_reg[7:6];
    // read-back select is dropped here
    assign cmd_hit  = is_write && (port_reg == ivt_pkg::PORT_CMD)
                      && (cmd_sel != ivt_pkg::SEL_READBACK);

    genvar gi;
    generate
        for (gi = 0; gi < ivt_pkg::NUM_CHANNELS; gi++)
        begin : g_chan
            assign ctl[gi].tick = is_tick;
            assign ctl[gi].rd   = is_read && chan_hit && (chan_idx == 2'(gi));
            assign ctl[gi].wr   = is_write && chan_hit && (chan_idx == 2'(gi));
            assign ctl[gi].cmd  = cmd_hit && (cmd_sel == 2'(gi));
            assign ctl[gi].data = data_reg;

            ivt_chan u_chan (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl[gi]),
                .sts   (sts[gi])
            );
        end
    endgenerate

    // Current channel 0 reload, tracked here for the tick-time IRQ interval
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reload0_reg <= '0;
        else
            reload0_reg <= sts[0].reload_next;
    end

    assign div0_cur   = ivt_pkg::divisor_of(reload0_reg);
    assign div0_new   = ivt_pkg::divisor_of(sts[0].reload_next);
    assign div2_new   = ivt_pkg::divisor_of(sts[2].reload_next);
    assign irq_cd_dec = (irq_cd_reg != 17'd0) ? 17'(irq_cd_reg - 17'd1) : 17'd0;

    always_comb
    begin
        elapsed_next  = elapsed_reg;
        gate_lvl_next = gate_lvl_reg;
        irq_en_next   = irq_en_reg;
        irq_cd_next   = irq_cd_reg;
        irq_pend_next = irq_pend_reg;
        fired_next    = 1'b0;

        if (is_tick)
        begin
            if (elapsed_reg < ElapsedMax)
                elapsed_next = 17'(elapsed_reg + 17'd1);
            if (irq_en_reg)
            begin
                irq_cd_next = irq_cd_dec;
                if (irq_cd_dec == 17'd0)
                begin
                    irq_pend_next = 1'b1;
                    irq_cd_next   = (div0_cur < MinTicks) ? MinTicks : div0_cur;
                end
            end
        end

        // a completed reload on channel 0 arms and reschedules the interrupt
        if (sts[0].restart)
        begin
            irq_en_next = 1'b1;
            irq_cd_next = (div0_new < MinTicks) ? MinTicks : div0_new;
        end
        if (sts[2].restart)
            elapsed_next = '0;

        if (is_gate)
        begin
            if (gate_in_reg && !gate_lvl_reg)
                elapsed_next = '0;
            gate_lvl_next = gate_in_reg;
        end

        if (is_poll)
        begin
            fired_next    = irq_pend_reg;
            irq_pend_next = 1'b0;
        end
    end

    always_comb
    begin
        read_data_next = 8'd0;
        if (is_read && chan_hit)
        begin
            unique case (chan_idx)
                2'd0:    read_data_next = sts[0].rd_data;
                2'd1:    read_data_next = sts[1].rd_data;
                default: read_data_next = sts[2].rd_data;
            endcase
        end
    end

    assign out2_next = gate_lvl_next && (elapsed_next >= div2_new);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg  <= '0;
            gate_lvl_reg <= 1'b0;
            irq_en_reg   <= 1'b0;
            irq_cd_reg   <= '0;
            irq_pend_reg <= 1'b0;
        end
        else
        begin
            elapsed_reg  <= elapsed_next;
            gate_lvl_reg <= gate_lvl_next;
            irq_en_reg   <= irq_en_next;
            irq_cd_reg   <= irq_cd_next;
            irq_pend_reg <= irq_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_data_reg <= read_data_next;
            fired_reg     <= fired_next;
            out2_reg      <= out2_next;
            gate_out_reg  <= gate_lvl_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign read_data  = read_data_reg;
    assign irq0_fired = fired_reg;
    assign out2_high  = out2_reg;
    assign gate_state = gate_out_reg;

    // Channel 2 output can only be high while its gate is high
    a_out2_gated: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (!out2_reg || gate_out_reg))
        else $error("out2_high without gate");

    // A poll always leaves the interrupt clear
    a_poll_clears: assert property (@(posedge clk) disable iff (!rst_n)
        is_poll |=> !irq_pend_reg)
        else $error("irq pending after poll");

    // Elapsed count saturates at 65536
    a_elapsed_sat: assert property (@(posedge clk) disable iff (!rst_n)
        elapsed_reg <= ElapsedMax)
        else $error("gate elapsed overflow");

    // Once armed, the interrupt stays armed
    a_irq_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        irq_en_reg |=> irq_en_reg)
        else $error("irq enable dropped");

endmodule

// ----- sv/ivt_chan.sv -----
module ivt_chan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ivt_pkg::chan_ctl_t    ctl,
    output ivt_pkg::chan_sts_t    sts
);

    logic [15:0] reload_reg, reload_next;
    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  access_reg, access_next;
    logic        wphase_reg, wphase_next;
    logic        rphase_reg, rphase_next;
    logic [15:0] latch_reg, latch_next;
    logic        held_reg, held_next;
    logic [15:0] count_reg, count_next;

    logic [15:0] rd_val;
    logic [2:0]  cmd_mode;
    logic        restart;
    logic [7:0]  rd_byte;

    assign rd_val = held_reg ? latch_reg : count_reg;
    // modes six and seven alias two and three
    assign cmd_mode = (ctl.data[3:1] > 3'd5) ? 3'(ctl.data[3:1] - 3'd4) : ctl.data[3:1];

    always_comb
    begin
        reload_next = reload_reg;
        mode_next   = mode_reg;
        access_next = access_reg;
        wphase_next = wphase_reg;
        rphase_next = rphase_reg;
        latch_next  = latch_reg;
        held_next   = held_reg;
        count_next  = count_reg;
        restart     = 1'b0;
        rd_byte     = 8'd0;

        if (ctl.tick)
        begin
            if ((mode_reg == ivt_pkg::MODE_RATE || mode_reg == ivt_pkg::MODE_SQUARE)
                && count_reg == 16'd1)
                count_next = reload_reg;
            else
                count_next = 16'(count_reg - 16'd1);
        end

        if (ctl.cmd)
        begin
            if (ctl.data[5:4] == ivt_pkg::ACC_LATCH)
            begin
                latch_next  = count_reg;
                held_next   = 1'b1;
                rphase_next = 1'b0;
            end
            else
            begin
                access_next = ctl.data[5:4];
                mode_next   = cmd_mode;
                wphase_next = 1'b0;
                rphase_next = 1'b0;
                held_next   = 1'b0;
            end
        end

        if (ctl.wr)
        begin
            unique case (access_reg)
                ivt_pkg::ACC_LO:
                begin
                    reload_next = {reload_reg[15:8], ctl.data};
                    restart     = 1'b1;
                end
                ivt_pkg::ACC_HI:
                begin
                    reload_next = {ctl.data, reload_reg[7:0]};
                    restart     = 1'b1;
                end
                default:
                begin
                    if (!wphase_reg)
                    begin
                        reload_next = {reload_reg[15:8], ctl.data};
                        wphase_next = 1'b1;
                    end
                    else
                    begin
                        reload_next = {ctl.data, reload_reg[7:0]};
                        wphase_next = 1'b0;
                        restart     = 1'b1;
                    end
                end
            endcase
            if (restart)
                count_next = reload_next;
        end

        if (ctl.rd)
        begin
            unique case (access_reg)
                ivt_pkg::ACC_LO:
                begin
                    held_next = 1'b0;
                    rd_byte   = rd_val[7:0];
                end
                ivt_pkg::ACC_HI:
                begin
                    held_next = 1'b0;
                    rd_byte   = rd_val[15:8];
                end
                default:
                begin
                    if (!rphase_reg)
                    begin
                        rphase_next = 1'b1;
                        rd_byte     = rd_val[7:0];
                    end
                    else
                    begin
                        rphase_next = 1'b0;
                        held_next   = 1'b0;
                        rd_byte     = rd_val[15:8];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= '0;
            mode_reg   <= '0;
            access_reg <= '0;
            wphase_reg <= 1'b0;
            rphase_reg <= 1'b0;
            latch_reg  <= '0;
            held_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            reload_reg <= reload_next;
            mode_reg   <= mode_next;
            access_reg <= access_next;
            wphase_reg <= wphase_next;
            rphase_reg <= rphase_next;
            latch_reg  <= latch_next;
            held_reg   <= held_next;
            count_reg  <= count_next;
        end
    end

    assign sts.rd_data     = rd_byte;
    assign sts.restart     = restart;
    assign sts.reload_next = reload_next;

endmodule

// ----- verif/tb_interval_timer_three_channel.sv -----
module tb_interval_timer_three_channel;

    localparam int IRQ_FLOOR      = 1193;
    localparam int RANDOM_ITEMS   = 780;
    localparam int SQUEEZE_CYCLES = 400;      // long receiver hold-off
    localparam int SQUEEZE_AFTER  = 150;      // results seen before the hold-off starts
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 3_000_000;

    // op codes the block does not define; it must only report its outputs
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] port;
        logic [7:0]  data;
        logic        gate;
    } timer_item_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       fired;
        logic       out2;
        logic       gate_lvl;
    } timer_result_t;

    // ------------------------------------------------------------------
    // Clock, reset, block ports (all inputs known from time 0)
    // ------------------------------------------------------------------
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [2:0]  op         = ivt_pkg::OP_TICK;
    logic [15:0] port       = '0;
    logic [7:0]  write_data = '0;
    logic        gate       = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  read_data;
    logic        irq0_fired;
    logic        out2_high;
    logic        gate_state;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    interval_timer_three_channel #(
        .MIN_IRQ_TICKS(IRQ_FLOOR)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .port(port),
        .write_data(write_data),
        .gate(gate),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_data(read_data),
        .irq0_fired(irq0_fired),
        .out2_high(out2_high),
        .gate_state(gate_state)
    );

    // ------------------------------------------------------------------
    // Timer state mirror, starts from the reset values (all zero)
    // ------------------------------------------------------------------
    logic [15:0] reload_q  [ivt_pkg::NUM_CHANNELS] = '{default: '0};
    logic [2:0]  mode_q    [ivt_pkg::NUM_CHANNELS] = '{default: '0};
    logic [1:0]  access_q  [ivt_pkg::NUM_CHANNELS] = '{default: '0};
    logic        wr_phase  [ivt_pkg::NUM_CHANNELS] = '{default: '0};
    logic        rd_phase  [ivt_pkg::NUM_CHANNELS] = '{default: '0};
    logic [15:0] latch_val [ivt_pkg::NUM_CHANNELS] = '{default: '0};
    logic        latch_on  [ivt_pkg::NUM_CHANNELS] = '{default: '0};
    logic [15:0] count_q   [ivt_pkg::NUM_CHANNELS] = '{default: '0};
    logic [16:0] gate_ticks = '0;   // ticks since channel 2 start, saturates at 65536
    logic        gate_now   = 1'b0;
    logic        irq_armed  = 1'b0;
    logic [16:0] irq_left   = '0;
    logic        irq_flag   = 1'b0;

    timer_item_t   item_backlog [$];   // items waiting to be offered
    timer_result_t results_owed [$];   // results the block still owes, oldest first

    int items_total     = 0;
    int items_taken     = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int cycle_count     = 0;

    function automatic logic [16:0] span_of(input logic [15:0] r);
        return (r == 16'd0) ? 17'h10000 : {1'b0, r};
    endfunction

    function automatic logic [16:0] irq_period();
        logic [16:0] s;
        s = span_of(reload_q[0]);
        return (s < IRQ_FLOOR) ? 17'(IRQ_FLOOR) : s;
    endfunction

    // Divisor masked to 16 bits is the reload value itself (65536 -> 0)
    function automatic void restart_counter(input int c);
        count_q[c] = reload_q[c];
        if (c == 0)
        begin
            irq_armed = 1'b1;
            irq_left  = irq_period();
        end
        if (c == 2)
            gate_ticks = '0;
    endfunction

    // Applies one item to the mirror and returns the result it produces
    function automatic timer_result_t timer_apply(input timer_item_t it);
        timer_result_t r;
        logic          on_chan;
        int            c;
        logic [15:0]   v;
        logic [2:0]    m;
        r       = '0;
        on_chan = (it.port >= ivt_pkg::PORT_CH0)
                  && (it.port <= ivt_pkg::PORT_CH0 + 16'(ivt_pkg::NUM_CHANNELS - 1));
        c       = on_chan ? int'(it.port - ivt_pkg::PORT_CH0) : 0;
        case (it.op)
            ivt_pkg::OP_TICK:
            begin
                for (int k = 0; k < ivt_pkg::NUM_CHANNELS; k++)
                begin
                    if ((mode_q[k] == ivt_pkg::MODE_RATE || mode_q[k] == ivt_pkg::MODE_SQUARE)
                        && count_q[k] == 16'd1)
                        count_q[k] = reload_q[k];
                    else
                        count_q[k] = count_q[k] - 16'd1;
                end
                if (gate_ticks < 17'h10000)
                    gate_ticks = gate_ticks + 17'd1;
                if (irq_armed)
                begin
                    if (irq_left != 0)
                        irq_left = irq_left - 17'd1;
                    if (irq_left == 0)
                    begin
                        irq_flag = 1'b1;
                        irq_left = irq_period();
                    end
                end
            end
            ivt_pkg::OP_READ:
            begin
                if (on_chan)
                begin
                    v = latch_on[c] ? latch_val[c] : count_q[c];
                    if (access_q[c] == ivt_pkg::ACC_LO)
                    begin
                        latch_on[c] = 1'b0;
                        r.rd        = v[7:0];
                    end
                    else if (access_q[c] == ivt_pkg::ACC_HI)
                    begin
                        latch_on[c] = 1'b0;
                        r.rd        = v[15:8];
                    end
                    else if (!rd_phase[c])
                    begin
                        rd_phase[c] = 1'b1;
                        r.rd        = v[7:0];
                    end
                    else
                    begin
                        rd_phase[c] = 1'b0;
                        latch_on[c] = 1'b0;
                        r.rd        = v[15:8];
                    end
                end
            end
            ivt_pkg::OP_WRITE:
            begin
                if (it.port == ivt_pkg::PORT_CMD)
                begin
                    c = int'(it.data[7:6]);
                    // read-back commands are dropped
                    if (it.data[7:6] != ivt_pkg::SEL_READBACK)
                    begin
                        if (it.data[5:4] == ivt_pkg::ACC_LATCH)
                        begin
                            latch_val[c] = count_q[c];
                            latch_on[c]  = 1'b1;
                            rd_phase[c]  = 1'b0;
                        end
                        else
                        begin
                            access_q[c] = it.data[5:4];
                            m = it.data[3:1];
                            if (m[2] && m[1])
                                m[2] = 1'b0;     // modes 6/7 alias to 2/3
                            mode_q[c]   = m;
                            wr_phase[c] = 1'b0;
                            rd_phase[c] = 1'b0;
                            latch_on[c] = 1'b0;
                        end
                    end
                end
                else if (on_chan)
                begin
                    if (access_q[c] == ivt_pkg::ACC_LO)
                    begin
                        reload_q[c][7:0] = it.data;
                        restart_counter(c);
                    end
                    else if (access_q[c] == ivt_pkg::ACC_HI)
                    begin
                        reload_q[c][15:8] = it.data;
                        restart_counter(c);
                    end
                    else if (!wr_phase[c])
                    begin
                        reload_q[c][7:0] = it.data;
                        wr_phase[c]      = 1'b1;
                    end
                    else
                    begin
                        reload_q[c][15:8] = it.data;
                        wr_phase[c]       = 1'b0;
                        restart_counter(c);
                    end
                end
            end
            ivt_pkg::OP_GATE:
            begin
                if (it.gate && !gate_now)
                    gate_ticks = '0;
                gate_now = it.gate;
            end
            ivt_pkg::OP_POLL:
            begin
                r.fired  = irq_flag;
                irq_flag = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.out2     = gate_now && (gate_ticks >= span_of(reload_q[2]));
        r.gate_lvl = gate_now;
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic logic [7:0] cmd_word(input logic [1:0] sel, input logic [1:0] acc,
                                           input logic [2:0] mode, input logic bcd);
        return {sel, acc, mode, bcd};
    endfunction

    // Fields the op does not use get random values so every bit toggles
    task automatic push_item(input logic [2:0] o, input logic [15:0] p,
                             input logic [7:0] d, input logic g);
        timer_item_t it;
        it.op   = o;
        it.port = p;
        it.data = (o == ivt_pkg::OP_WRITE) ? d : 8'($urandom);
        it.gate = (o == ivt_pkg::OP_GATE) ? g : 1'($urandom);
        item_backlog.push_back(it);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers items from the backlog, holds payload while stalled.
    // An item counts as transferred at the edge where valid is high and
    // stall is low; it is applied to the mirror right there.
    // ------------------------------------------------------------------
    timer_item_t   tx_item;
    timer_result_t tx_res;
    int unsigned   tx_idle;
    int unsigned   tx_calm;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_idle  <= 0;
            tx_calm  <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                tx_res = timer_apply(tx_item);
                results_owed.push_back(tx_res);
                items_taken <= items_taken + 1;
            end
            if (tx_idle != 0)
            begin
                tx_idle  <= tx_idle - 1;
                in_valid <= 1'b0;
            end
            else if (item_backlog.size() != 0)
            begin
                tx_item     = item_backlog.pop_front();
                op         <= tx_item.op;
                port       <= tx_item.port;
                write_data <= tx_item.data;
                gate       <= tx_item.gate;
                in_valid   <= 1'b1;
                // calm stretch: back-to-back items with no gaps
                if (tx_calm != 0)
                    tx_calm <= tx_calm - 1;
                else
                begin
                    tx_idle <= idle_len();
                    if ($urandom_range(0, 39) == 0)
                        tx_calm <= $urandom_range(20, 80);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: random holds, calm stretches, and one long hold-off
    // so both pipeline registers fill and in_stall backs up.
    // ------------------------------------------------------------------
    int unsigned rx_hold;
    int unsigned rx_calm;
    int unsigned rx_n;
    logic        squeeze_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            rx_hold      <= 0;
            rx_calm      <= 0;
            squeeze_done <= 1'b0;
        end
        else if (!squeeze_done && results_checked >= SQUEEZE_AFTER)
        begin
            squeeze_done <= 1'b1;
            out_stall    <= 1'b1;
            rx_hold      <= SQUEEZE_CYCLES - 1;
        end
        else if (rx_hold != 0)
        begin
            rx_hold   <= rx_hold - 1;
            out_stall <= 1'b1;
        end
        else if (rx_calm != 0)
        begin
            rx_calm   <= rx_calm - 1;
            out_stall <= 1'b0;
        end
        else
        begin
            rx_n       = idle_len();
            out_stall <= (rx_n != 0);
            rx_hold   <= (rx_n != 0) ? rx_n - 1 : 0;
            if ($urandom_range(0, 39) == 0)
                rx_calm <= $urandom_range(20, 80);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result transfer is matched against the oldest owed one
    // ------------------------------------------------------------------
    timer_result_t rx_got;
    timer_result_t rx_want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            rx_got = {read_data, irq0_fired, out2_high, gate_state};
            if (results_owed.size() == 0)
            begin
                $display("%0t: unexpected result: rd %h fired %b out2 %b gate %b",
                         $time, rx_got.rd, rx_got.fired, rx_got.out2, rx_got.gate_lvl);
                mismatches++;
            end
            else
            begin
                rx_want = results_owed.pop_front();
                if (rx_got !== rx_want)
                begin
                    $display("%0t: mismatch read_data exp %h got %h, irq0_fired exp %b got %b",
                             $time, rx_want.rd, rx_got.rd, rx_want.fired, rx_got.fired);
                    $display("%0t:          out2_high exp %b got %b, gate_state exp %b got %b",
                             $time, rx_want.out2, rx_got.out2, rx_want.gate_lvl,
                             rx_got.gate_lvl);
                    mismatches++;
                end
            end
            results_checked <= results_checked + 1;
        end
    end

    // Hard stop if the run hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL interval_timer_three_channel");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int          kind;
        int          n;
        int          counted;
        logic [1:0]  ch;
        logic [1:0]  acc;
        logic [2:0]  rmode;
        logic [15:0] cport;
        logic [7:0]  b;

        // Directed: reset values, counter wrap, latch, read-back, mode alias,
        // gate rising edge and out2, reload of zero, odd ports, undefined ops
        push_item(ivt_pkg::OP_READ, ivt_pkg::PORT_CH0, 8'h00, 1'b0);
        push_item(ivt_pkg::OP_READ, ivt_pkg::PORT_CH0, 8'h00, 1'b0);
        push_item(ivt_pkg::OP_TICK, 16'h0000, 8'h00, 1'b0);      // 0 wraps to ffff
        push_item(ivt_pkg::OP_WRITE, ivt_pkg::PORT_CMD,
                  cmd_word(2'd0, ivt_pkg::ACC_LATCH, 3'd0, 1'b0), 1'b0);
        push_item(ivt_pkg::OP_TICK, 16'h0000, 8'h00, 1'b0);
        push_item(ivt_pkg::OP_READ, ivt_pkg::PORT_CH0, 8'h00, 1'b0);   // latched value, low
        push_item(ivt_pkg::OP_READ, ivt_pkg::PORT_CH0, 8'h00, 1'b0);   // then high
        push_item(ivt_pkg::OP_WRITE, ivt_pkg::PORT_CMD,
                  cmd_word(ivt_pkg::SEL_READBACK, ivt_pkg::ACC_LOHI, '1, 1'b1), 1'b0);
        push_item(ivt_pkg::OP_WRITE, ivt_pkg::PORT_CMD,
                  cmd_word(2'd2, ivt_pkg::ACC_LOHI, 3'b111, 1'b0), 1'b0);
        push_item(ivt_pkg::OP_WRITE, ivt_pkg::PORT_CH0 + 16'd2, 8'd3, 1'b0);
        push_item(ivt_pkg::OP_WRITE, ivt_pkg::PORT_CH0 + 16'd2, 8'd0, 1'b0);
        push_item(ivt_pkg::OP_GATE, 16'h0000, 8'h00, 1'b1);
        repeat (3)
            push_item(ivt_pkg::OP_TICK, 16'h0000, 8'h00, 1'b0);  // out2 rises on the third
        push_item(ivt_pkg::OP_GATE, 16'h0000, 8'h00, 1'b0);
        push_item(ivt_pkg::OP_GATE, 16'h0000, 8'h00, 1'b1);
        push_item(ivt_pkg::OP_WRITE, ivt_pkg::PORT_CMD,
                  cmd_word(2'd1, ivt_pkg::ACC_HI, 3'b110, 1'b0), 1'b0);
        push_item(ivt_pkg::OP_WRITE, ivt_pkg::PORT_CH0 + 16'd1, 8'hFF, 1'b0);
        push_item(ivt_pkg::OP_READ, ivt_pkg::PORT_CH0 + 16'd1, 8'h00, 1'b0);
        push_item(ivt_pkg::OP_WRITE, ivt_pkg::PORT_CMD,
                  cmd_word(2'd0, ivt_pkg::ACC_LO, 3'd0, 1'b0), 1'b0);
        push_item(ivt_pkg::OP_WRITE, ivt_pkg::PORT_CH0, 8'h00, 1'b0);  // reload 0 = 65536
        push_item(ivt_pkg::OP_READ, ivt_pkg::PORT_CMD, 8'h00, 1'b0);
        push_item(ivt_pkg::OP_READ, 16'hFFFF, 8'h00, 1'b0);
        push_item(ivt_pkg::OP_WRITE, 16'h0000, 8'hFF, 1'b0);
        push_item(ivt_pkg::OP_POLL, 16'h0000, 8'h00, 1'b0);
        push_item(OP_UNUSED_LO, 16'h0000, 8'h00, 1'b0);
        push_item(OP_UNUSED_HI, 16'hFFFF, 8'hFF, 1'b1);

        // Random: mostly well-formed command/data sequences, some noise
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            kind  = $urandom_range(0, 99);
            ch    = 2'($urandom_range(0, ivt_pkg::NUM_CHANNELS - 1));
            cport = ivt_pkg::PORT_CH0 + 16'(ch);
            if (kind < 18)
            begin
                // program: control word then the data bytes its access mode wants,
                // occasionally one byte short
                acc   = 2'($urandom_range(ivt_pkg::ACC_LO, ivt_pkg::ACC_LOHI));
                rmode = 3'($urandom);
                push_item(ivt_pkg::OP_WRITE, ivt_pkg::PORT_CMD,
                          cmd_word(ch, acc, rmode, 1'($urandom)), 1'b0);
                n = (acc == ivt_pkg::ACC_LOHI) ? 2 : 1;
                if ($urandom_range(0, 9) == 0)
                    n--;
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        b = 8'($urandom);
                    else if (k == 0 && acc != ivt_pkg::ACC_HI)
                        b = 8'($urandom_range(0, 12));
                    else
                        b = 8'h00;
                    push_item(ivt_pkg::OP_WRITE, cport, b, 1'b0);
                end
                counted += 1 + n;
            end
            else if (kind < 30)
            begin
                push_item(ivt_pkg::OP_WRITE, ivt_pkg::PORT_CMD,
                          cmd_word(ch, ivt_pkg::ACC_LATCH, 3'($urandom), 1'($urandom)), 1'b0);
                n = $urandom_range(1, 3);
                repeat (n)
                    push_item(ivt_pkg::OP_READ, cport, 8'h00, 1'b0);
                counted += 1 + n;
            end
            else if (kind < 42)
            begin
                n = $urandom_range(1, 2);
                repeat (n)
                    push_item(ivt_pkg::OP_READ, cport, 8'h00, 1'b0);
                counted += n;
            end
            else if (kind < 70)
            begin
                n = $urandom_range(1, 24);
                repeat (n)
                    push_item(ivt_pkg::OP_TICK, 16'($urandom), 8'h00, 1'b0);
                counted += n;
            end
            else if (kind < 78)
            begin
                push_item(ivt_pkg::OP_GATE, 16'($urandom), 8'h00, 1'($urandom));
                counted++;
            end
            else if (kind < 84)
            begin
                push_item(ivt_pkg::OP_POLL, 16'($urandom), 8'h00, 1'b0);
                counted++;
            end
            else if (kind < 90)
            begin
                // stray data byte, breaks any half-done low/high pair
                push_item(ivt_pkg::OP_WRITE, cport, 8'($urandom), 1'b0);
                counted++;
            end
            else
            begin
                push_item(3'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
                counted++;
            end
        end

        items_total = item_backlog.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // sample at the falling edge, away from the driving edge
        while (items_taken != items_total)
            @(negedge clk);
        while (results_owed.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("PASS interval_timer_three_channel");
        else
            $display("FAIL interval_timer_three_channel");
        $finish;
    end

endmodule
